/* rtl/slcm_pkg.sv */
// slcm_pkg: shared types, sizes and codes for the single-linkage cluster merger.
// No dependencies.
`timescale 1ns / 1ps
package slcm_pkg;
  localparam int MAX_SCANS = 1024;
  localparam int ID_W      = 10;
  localparam int CNT_W     = 11;

  typedef enum logic [1:0] {
    ST_MERGED = 2'd0,
    ST_SAME   = 2'd1,
    ST_REJECT = 2'd2,
    ST_QUERY  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_GETA,
    S_GETB,
    S_RDK,
    S_GETK,
    S_GETG,
    S_WALK,
    S_APP,
    S_KEEP,
    S_QGET,
    S_QCNT,
    S_DONE
  } state_t;

  // one memory word per scan id
  typedef struct packed {
    logic             seen;
    logic [ID_W-1:0]  root;
    logic [ID_W-1:0]  link;
    logic [ID_W-1:0]  tail;
    logic [CNT_W-1:0] count;
  } entry_t;
endpackage

/* rtl/single_linkage_cluster_merger_top.sv */
// single_linkage_cluster_merger_top: union-find cluster merger with member lists.
// Depends on slcm_pkg.
`timescale 1ns / 1ps
// Usage:
//   Input: drive in_kind, in_id_a, in_id_b, in_pval with start high; the beat
//   is taken on a rising edge where busy is low. One item at a time; busy
//   stays high until the result strobe cycle is over.
//   Result: out_valid is high for exactly one cycle with out_status,
//   out_root_id and out_cluster_size. The receiver cannot stall.
//   Config: cfg_we writes cfg_data into the cut threshold (signed Q8.8);
//   write it only while idle.
// Sequence (the strobe is the S_DONE state; the next beat can be taken
// in the cycle after the strobe):
//   rejected pair: straight to the strobe
//   query: root of the id, then its count if the id was seen
//   pair already in one cluster: reads of a, b and the survivor root
//   merge: as above, then each member of the absorbed cluster is relabelled
//   and the survivor tail and root are rewritten; the relabel walk visits
//   one member per cycle through the single registered read port of the entry memory.
// Reset: rst_n low restores the cut threshold to 32767. After release a
//   clearing pass (busy high) zeroes all 1024 entries, so every seen bit
//   reads clear; other fields are read only after being written.
module single_linkage_cluster_merger_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_kind,
  input  logic [slcm_pkg::ID_W-1:0]   in_id_a,
  input  logic [slcm_pkg::ID_W-1:0]   in_id_b,
  input  logic signed [15:0]          in_pval,
  input  logic                        cfg_we,
  input  logic signed [15:0]          cfg_data,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [slcm_pkg::ID_W-1:0]   out_root_id,
  output logic [slcm_pkg::CNT_W-1:0]  out_cluster_size
);
  import slcm_pkg::*;

  // entry memory: one write port, one registered read port
  entry_t ent_mem [MAX_SCANS];
  entry_t rdata_r;
  logic mem_we;
  logic [ID_W-1:0] mem_wa, mem_ra;
  entry_t mem_wd;

  state_t state_r, state_nxt;
  logic signed [15:0] cut_r;
  logic [ID_W-1:0] clr_r, clr_nxt;
  logic [ID_W-1:0] a_r, a_nxt, b_r, b_nxt, ra_r, ra_nxt;
  logic [ID_W-1:0] keep_r, keep_nxt, gone_r, gone_nxt, cur_r, cur_nxt;
  logic [ID_W-1:0] klast_r, klast_nxt, glast_r, glast_nxt;
  logic [CNT_W-1:0] ksz_r, ksz_nxt, n_r, n_nxt, i_r, i_nxt;
  entry_t kword_r, kword_nxt;
  status_t st_r, st_nxt;
  logic [ID_W-1:0] orid_r, orid_nxt;
  logic [CNT_W-1:0] osz_r, osz_nxt;

  logic acc, clr_last, gone_multi, walk_more;
  logic [ID_W-1:0] rb_w;
  logic [CNT_W-1:0] sum_w;
  entry_t relab_w;

  function automatic entry_t singleton(input logic [ID_W-1:0] id);
    entry_t e;
    e.seen  = 1'b1;
    e.root  = id;
    e.link  = id;
    e.tail  = id;
    e.count = CNT_W'(1);
    return e;
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) ent_mem[mem_wa] <= mem_wd;
    rdata_r <= ent_mem[mem_ra];
  end

  assign acc      = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign clr_last = (clr_r == ID_W'(MAX_SCANS - 1));
  // b equal to a: a may have been written in S_GETA while b was read, use its root
  assign rb_w     = (b_r == a_r) ? ra_r : (rdata_r.seen ? rdata_r.root : b_r);
  assign gone_multi = (rdata_r.count > CNT_W'(1));
  assign walk_more  = ((i_r + CNT_W'(1)) < n_r);
  assign sum_w    = ksz_r + n_r;
  assign relab_w  = {rdata_r.seen, keep_r, rdata_r.link, rdata_r.tail, rdata_r.count};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_last) state_nxt = S_IDLE;
      S_IDLE: if (acc) begin
        if (in_kind) state_nxt = S_QGET;
        else if (in_pval > cut_r) state_nxt = S_DONE;
        else state_nxt = S_GETA;
      end
      S_GETA: state_nxt = S_GETB;
      S_GETB: state_nxt = S_RDK;
      S_RDK:  state_nxt = S_GETK;
      S_GETK: state_nxt = (st_r == ST_SAME) ? S_DONE : S_GETG;
      S_GETG: state_nxt = gone_multi ? S_WALK : S_APP;
      S_WALK: state_nxt = walk_more ? S_WALK : S_APP;
      S_APP:  state_nxt = S_KEEP;
      S_KEEP: state_nxt = S_DONE;
      S_QGET: state_nxt = rdata_r.seen ? S_QCNT : S_DONE;
      S_QCNT: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory controls and datapath
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_r;
    mem_wd = rdata_r;
    mem_ra = in_id_a;
    clr_nxt = clr_r;
    a_nxt = a_r; b_nxt = b_r; ra_nxt = ra_r;
    keep_nxt = keep_r; gone_nxt = gone_r; cur_nxt = cur_r;
    klast_nxt = klast_r; glast_nxt = glast_r;
    ksz_nxt = ksz_r; n_nxt = n_r; i_nxt = i_r;
    kword_nxt = kword_r; st_nxt = st_r;
    orid_nxt = orid_r; osz_nxt = osz_r;
    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1; mem_wa = clr_r; mem_wd = '0;
        clr_nxt = clr_r + ID_W'(1);
      end
      S_IDLE: if (acc) begin
        a_nxt = in_id_a; b_nxt = in_id_b;
        if (in_kind) st_nxt = ST_QUERY;
        else if (in_pval > cut_r) begin
          st_nxt = ST_REJECT; orid_nxt = '0; osz_nxt = '0;
        end
      end
      S_GETA: begin
        mem_ra = b_r;
        if (!rdata_r.seen) begin
          mem_we = 1'b1; mem_wa = a_r; mem_wd = singleton(a_r);
          ra_nxt = a_r;
        end else begin
          ra_nxt = rdata_r.root;
        end
      end
      S_GETB: begin
        if ((b_r != a_r) && !rdata_r.seen) begin
          mem_we = 1'b1; mem_wa = b_r; mem_wd = singleton(b_r);
        end
        keep_nxt = (ra_r < rb_w) ? ra_r : rb_w;
        gone_nxt = (ra_r < rb_w) ? rb_w : ra_r;
        st_nxt   = (ra_r == rb_w) ? ST_SAME : ST_MERGED;
      end
      S_RDK: mem_ra = keep_r;
      S_GETK: begin
        mem_ra = gone_r;
        ksz_nxt = rdata_r.count; klast_nxt = rdata_r.tail; kword_nxt = rdata_r;
        if (st_r == ST_SAME) begin
          orid_nxt = keep_r; osz_nxt = rdata_r.count;
        end
      end
      S_GETG: begin
        // first walk step: the absorbed root itself
        n_nxt = rdata_r.count; glast_nxt = rdata_r.tail;
        mem_we = 1'b1; mem_wa = gone_r; mem_wd = relab_w;
        i_nxt = CNT_W'(1);
        if (gone_multi) begin
          mem_ra = rdata_r.link; cur_nxt = rdata_r.link;
        end else begin
          mem_ra = klast_r;
        end
      end
      S_WALK: begin
        mem_we = 1'b1; mem_wa = cur_r; mem_wd = relab_w;
        i_nxt = i_r + CNT_W'(1);
        if (walk_more) begin
          mem_ra = rdata_r.link; cur_nxt = rdata_r.link;
        end else begin
          mem_ra = klast_r;
        end
      end
      S_APP: begin
        // tail of the survivor, unless it is the root, now links to the absorbed root
        if (klast_r != keep_r) begin
          mem_we = 1'b1; mem_wa = klast_r;
          mem_wd = {rdata_r.seen, rdata_r.root, gone_r, rdata_r.tail, rdata_r.count};
        end
      end
      S_KEEP: begin
        mem_we = 1'b1; mem_wa = keep_r;
        mem_wd = {kword_r.seen, kword_r.root,
                  (klast_r == keep_r) ? gone_r : kword_r.link, glast_r, sum_w};
        orid_nxt = keep_r; osz_nxt = sum_w;
      end
      S_QGET: begin
        if (!rdata_r.seen) begin
          orid_nxt = a_r; osz_nxt = '0;
        end else begin
          mem_ra = rdata_r.root; orid_nxt = rdata_r.root;
        end
      end
      S_QCNT: osz_nxt = rdata_r.count;
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      cut_r <= 16'sd32767;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      if (cfg_we) cut_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; ra_r <= ra_nxt;
    keep_r <= keep_nxt; gone_r <= gone_nxt; cur_r <= cur_nxt;
    klast_r <= klast_nxt; glast_r <= glast_nxt;
    ksz_r <= ksz_nxt; n_r <= n_nxt; i_r <= i_nxt;
    kword_r <= kword_nxt; st_r <= st_nxt;
    orid_r <= orid_nxt; osz_r <= osz_nxt;
  end

  assign out_valid        = (state_r == S_DONE);
  assign out_status       = st_r;
  assign out_root_id      = orid_r;
  assign out_cluster_size = osz_r;
endmodule

/* rtl/slcm_checker.sv */
// slcm_checker: port-level assertions for the cluster merger, with bind.
// Depends on slcm_pkg and single_linkage_cluster_merger_top ports.
`timescale 1ns / 1ps
module slcm_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic [1:0] out_status,
  input logic [10:0] out_cluster_size
);
  import slcm_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_REJECT) |-> out_cluster_size == 11'd0)
    else $error("reject with nonzero size");
  a_merge_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_MERGED)) |-> out_cluster_size >= 11'd2)
    else $error("merge size too small");
endmodule

bind single_linkage_cluster_merger_top slcm_checker u_slcm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_cluster_size(out_cluster_size)
);
